// File: rtl/core/voxel_block_majority_downsample_top_assert.svh
// Assertion macros shared by the voxel block majority downsampler.
// Each use expects clk_i and rst_ni in the enclosing module.
`ifndef VOXEL_BLOCK_MAJORITY_DOWNSAMPLE_TOP_ASSERT_SVH
`define VOXEL_BLOCK_MAJORITY_DOWNSAMPLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define VBMD_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VBMD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/vbmd_pkg.sv
package vbmd_pkg;

  localparam int unsigned Divisor          = 2;
  localparam int unsigned NumVoxels        = Divisor * Divisor * Divisor;
  localparam int unsigned VoxelW           = 8;
  localparam int unsigned LabelBitsDefault = 8;
  localparam int unsigned CntW             = $clog2(NumVoxels + 1);
  // winners left after the first reduction stage
  localparam int unsigned FirstReduceOut   = 2;

  typedef logic [VoxelW-1:0] label_t;
  typedef logic [CntW-1:0]   cnt_t;

  // True when the candidate (label, count) displaces the current best:
  // higher count wins; on equal counts a nonzero label beats zero and the
  // smaller nonzero label wins.
  function automatic logic beats(label_t cand_lab, cnt_t cand_cnt,
                                 label_t best_lab, cnt_t best_cnt);
    logic res;
    if (cand_cnt != best_cnt) begin
      res = (cand_cnt > best_cnt);
    end else if (cand_lab == '0) begin
      res = 1'b0;
    end else if (best_lab == '0) begin
      res = 1'b1;
    end else begin
      res = (cand_lab < best_lab);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/vbmd_count.sv
// Occurrence count of each voxel label within its block, one register stage.
module vbmd_count #(
  parameter int unsigned LabelW = vbmd_pkg::VoxelW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [LabelW-1:0]     label_i [vbmd_pkg::NumVoxels],
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [LabelW-1:0]     label_o [vbmd_pkg::NumVoxels],
  output vbmd_pkg::cnt_t        cnt_o   [vbmd_pkg::NumVoxels]
);

  logic           valid_q;
  logic [LabelW-1:0] label_q [vbmd_pkg::NumVoxels];
  vbmd_pkg::cnt_t cnt_d   [vbmd_pkg::NumVoxels];
  vbmd_pkg::cnt_t cnt_q   [vbmd_pkg::NumVoxels];

  // hold while a result sits here and downstream is stalled
  assign stall_o = valid_q && stall_i;

  always_comb begin
    for (int i = 0; i < vbmd_pkg::NumVoxels; i++) begin
      cnt_d[i] = '0;
      for (int j = 0; j < vbmd_pkg::NumVoxels; j++) begin
        cnt_d[i] = cnt_d[i] + vbmd_pkg::cnt_t'(label_i[i] == label_i[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      label_q <= label_i;
      cnt_q   <= cnt_d;
    end
  end

  assign valid_o = valid_q;
  assign label_o = label_q;
  assign cnt_o   = cnt_q;

endmodule

// File: rtl/core/vbmd_reduce.sv
// Pick the winning (label, count) of each group of inputs, one register stage.
module vbmd_reduce #(
  parameter int unsigned LabelW = vbmd_pkg::VoxelW,
  parameter int unsigned InN    = vbmd_pkg::NumVoxels,
  parameter int unsigned OutN   = vbmd_pkg::FirstReduceOut
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [LabelW-1:0] label_i [InN],
  input  vbmd_pkg::cnt_t    cnt_i   [InN],
  output logic              valid_o,
  input  logic              stall_i,
  output logic [LabelW-1:0] label_o [OutN],
  output vbmd_pkg::cnt_t    cnt_o   [OutN]
);

  localparam int unsigned GroupN = InN / OutN;

  logic              valid_q;
  logic [LabelW-1:0] label_d [OutN];
  logic [LabelW-1:0] label_q [OutN];
  vbmd_pkg::cnt_t    cnt_d   [OutN];
  vbmd_pkg::cnt_t    cnt_q   [OutN];

  assign stall_o = valid_q && stall_i;

  always_comb begin
    for (int g = 0; g < OutN; g++) begin
      label_d[g] = label_i[g * GroupN];
      cnt_d[g]   = cnt_i[g * GroupN];
      for (int k = 1; k < GroupN; k++) begin
        if (vbmd_pkg::beats(vbmd_pkg::label_t'(label_i[g * GroupN + k]),
                            cnt_i[g * GroupN + k],
                            vbmd_pkg::label_t'(label_d[g]), cnt_d[g])) begin
          label_d[g] = label_i[g * GroupN + k];
          cnt_d[g]   = cnt_i[g * GroupN + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      label_q <= label_d;
      cnt_q   <= cnt_d;
    end
  end

  assign valid_o = valid_q;
  assign label_o = label_q;
  assign cnt_o   = cnt_q;

endmodule

// File: rtl/core/voxel_block_majority_downsample_top.sv
// Majority-vote 2x2x2 downsampler: each transfer carries the eight labels of
// one voxel block and yields one transfer with the most frequent label; on a
// tied count a nonzero label beats zero and the smallest nonzero label wins.
// Blocks are independent, so the pipeline takes one transfer per cycle while
// out_stall_i does not hold it; its stages are the input register, label count,
// 8-to-2 vote and 2-to-1 vote into the output register. Every stage holds
// its own valid bit and loads whenever it is empty or its successor moves, so
// bubbles collapse and a full pipe stalls in place; in_stall_o follows
// out_stall_i combinationally through that chain. LABEL_BITS masks the labels
// before comparison (labels beyond 8 bits are not possible on these ports).
`include "voxel_block_majority_downsample_top_assert.svh"

module voxel_block_majority_downsample_top #(
  parameter int unsigned LABEL_BITS = vbmd_pkg::LabelBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vbmd_pkg::label_t     voxel_0_i,
  input  vbmd_pkg::label_t     voxel_1_i,
  input  vbmd_pkg::label_t     voxel_2_i,
  input  vbmd_pkg::label_t     voxel_3_i,
  input  vbmd_pkg::label_t     voxel_4_i,
  input  vbmd_pkg::label_t     voxel_5_i,
  input  vbmd_pkg::label_t     voxel_6_i,
  input  vbmd_pkg::label_t     voxel_7_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vbmd_pkg::label_t     majority_label_o
);

  // compared label width: the field width caps the mask
  localparam int unsigned LabelW =
      (LABEL_BITS < vbmd_pkg::VoxelW) ? LABEL_BITS : vbmd_pkg::VoxelW;
  localparam int unsigned NumVox = vbmd_pkg::NumVoxels;
  localparam int unsigned MidN   = vbmd_pkg::FirstReduceOut;

  // Stage 1: input register with masked labels.
  logic              s1_valid_q;
  logic              s1_stall;
  logic [LabelW-1:0] s1_label_d [NumVox];
  logic [LabelW-1:0] s1_label_q [NumVox];

  // Stage 2: labels with their counts.
  logic              cnt_valid;
  logic              cnt_stall;
  logic [LabelW-1:0] cnt_label [NumVox];
  vbmd_pkg::cnt_t    cnt_cnt   [NumVox];

  // Stage 3: two group winners.
  logic              mid_valid;
  logic              mid_stall;
  logic [LabelW-1:0] mid_label [MidN];
  vbmd_pkg::cnt_t    mid_cnt   [MidN];

  // Stage 4: final winner, the output register.
  logic              fin_valid;
  logic              fin_stall;
  logic [LabelW-1:0] fin_label [1];
  vbmd_pkg::cnt_t    fin_cnt   [1];

  // drop bits above the label width
  always_comb begin
    s1_label_d[0] = voxel_0_i[LabelW-1:0];
    s1_label_d[1] = voxel_1_i[LabelW-1:0];
    s1_label_d[2] = voxel_2_i[LabelW-1:0];
    s1_label_d[3] = voxel_3_i[LabelW-1:0];
    s1_label_d[4] = voxel_4_i[LabelW-1:0];
    s1_label_d[5] = voxel_5_i[LabelW-1:0];
    s1_label_d[6] = voxel_6_i[LabelW-1:0];
    s1_label_d[7] = voxel_7_i[LabelW-1:0];
  end

  // hold the input stage only while it is full and the count stage is held
  assign s1_stall   = s1_valid_q && cnt_stall;
  assign in_stall_o = s1_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !s1_stall) begin
      s1_label_q <= s1_label_d;
    end
  end

  vbmd_count #(
    .LabelW (LabelW)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .stall_o (cnt_stall),
    .label_i (s1_label_q),
    .valid_o (cnt_valid),
    .stall_i (mid_stall),
    .label_o (cnt_label),
    .cnt_o   (cnt_cnt)
  );

  // groups of four voxels vote first
  vbmd_reduce #(
    .LabelW (LabelW),
    .InN    (NumVox),
    .OutN   (MidN)
  ) u_reduce_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cnt_valid),
    .stall_o (mid_stall),
    .label_i (cnt_label),
    .cnt_i   (cnt_cnt),
    .valid_o (mid_valid),
    .stall_i (fin_stall),
    .label_o (mid_label),
    .cnt_o   (mid_cnt)
  );

  // the two group winners meet in the output register
  vbmd_reduce #(
    .LabelW (LabelW),
    .InN    (MidN),
    .OutN   (1)
  ) u_reduce_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .stall_o (fin_stall),
    .label_i (mid_label),
    .cnt_i   (mid_cnt),
    .valid_o (fin_valid),
    .stall_i (out_stall_i),
    .label_o (fin_label),
    .cnt_o   (fin_cnt)
  );

  assign out_valid_o      = fin_valid;
  assign majority_label_o = vbmd_pkg::label_t'(fin_label[0]);

  // An empty output register must never back-pressure the input.
  `VBMD_ASSERT_HOLDS(a_empty_no_stall, !fin_valid, !in_stall_o,
                     "input stalled while the output register is empty")
  // An input item that advances must show up in the count stage.
  `VBMD_ASSERT_NEXT(a_s1_advance, s1_valid_q && !cnt_stall, cnt_valid,
                    "item lost between input and count stage")
  // Every voxel counts at least itself; the check looks at voxel 0.
  `VBMD_ASSERT_HOLDS(a_cnt_nonzero, cnt_valid, cnt_cnt[0] != '0,
                     "voxel count of zero in count stage")
  // A group winner never has a smaller count than the voxel it beat.
  `VBMD_ASSERT_NEXT(a_mid_winner, cnt_valid && !mid_stall,
                    mid_cnt[0] >= $past(cnt_cnt[0]),
                    "group winner count below a member count")
  // The final winner carries a nonzero count.
  `VBMD_ASSERT_HOLDS(a_fin_nonzero, fin_valid, fin_cnt[0] != '0,
                     "final winner with zero count")

endmodule
